[rtl/core/grid_cell_point_reduction_core_assert.svh]
// assertion macros used by the checker file gcpr_checker.sv
`ifndef GRID_CELL_POINT_REDUCTION_CORE_ASSERT_SVH
`define GRID_CELL_POINT_REDUCTION_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define GCPR_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication outside reset
`define GCPR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/gcpr_pkg.sv]
// shared types, constants and codes of the grid cell point reduction block
package gcpr_pkg;
    localparam int unsigned MAX_POINTS_DEF = 65536;
    localparam logic [31:0] FILL_RESET = 32'hFFFF_FC19;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FILL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FILL = 2'd2;
    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_WMEAN = 2'd1;
    localparam logic [1:0] MODE_NEAREST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    // start/done handshake between sequencer and serial units
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;
endpackage

[rtl/core/gcpr_mul.sv]
// bit-serial unsigned 32x32 multiplier, one multiplier bit per cycle
module gcpr_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output gcpr_pkg::unit_ctl_t ctl,
    output logic [63:0] prod
);
    logic [63:0] acc_reg, acc_next;
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            mcand_next = {32'd0, a};
            mplier_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next = {mcand_reg[62:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign prod = acc_reg;
endmodule

[rtl/core/gcpr_sqrt.sv]
// digit-by-digit integer square root of a 64-bit value, one result bit per cycle
module gcpr_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output gcpr_pkg::unit_ctl_t ctl,
    output logic [31:0] root
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] rad_reg, rad_next;
    logic [31:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] trial;
    logic [65:0] rem_sh;

    always_comb
    begin
        rem_next = rem_reg;
        rad_next = rad_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, rad_reg[63:62]};
        trial = {32'd0, root_reg, 2'b01};
        if (start)
        begin
            rem_next = '0;
            rad_next = radicand;
            root_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = 64'(rem_sh - trial);
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        rad_reg <= rad_next;
        root_reg <= root_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign root = root_reg;
endmodule

[rtl/core/gcpr_div.sv]
// restoring 64/64 unsigned divider, one quotient bit per cycle
module gcpr_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output gcpr_pkg::unit_ctl_t ctl,
    output logic [63:0] quotient
);
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] rem_sh;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh = {rem_reg, quo_reg[63]};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = 64'(rem_sh - {1'b0, dsr_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
    assign quotient = quo_reg;
endmodule

[rtl/core/grid_cell_point_reduction_core.sv]
// top level of the grid cell point reduction block
// usage:
// - input channel (valid/ready) carries one point per transfer: sample, point and
//   centre coordinates, cell index, has_point and last_point
// - output channel (valid/ready) carries one result per ended cell
// - a cell ends on last_point or on a marker item without a point
// - config writes (cfg_we, cfg_index, cfg_data) belong only in idle periods
// timing:
// - one item at a time; ready is low while an item is in work
// - mean mode point: added straight to the sum; nearest mode: the bit-serial
//   multiplier runs twice, squaring dx and then dy
// - weighted point: squares of dx and dy, then the root, then the sample multiply
// - ending item in the mean modes runs the divider unless the cell is empty
// reset:
// - registers return to mode mean and fill -999; accumulators clear, nearest distance to all ones
// stall:
// - a result holds in the output register until its transfer; the next
//   item is taken only after that, since a result follows at most one item
module grid_cell_point_reduction_core #(
    parameter int unsigned MAX_POINTS = gcpr_pkg::MAX_POINTS_DEF,
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] centre_x,
    input  logic signed [31:0] centre_y,
    input  logic [19:0]        cell_index,
    input  logic               has_point,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cell_value,
    output logic [19:0]        cell_position,
    output logic               used_fill
);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // configuration registers
    logic [1:0]  mode_reg;
    logic [31:0] in_fill_reg;
    logic [31:0] out_fill_reg;

    // cell accumulators
    logic signed [63:0] sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [63:0]        dtot_reg, dtot_next;
    logic [63:0]        nd2_reg, nd2_next;
    logic [31:0]        nval_reg, nval_next;
    logic               nseen_reg, nseen_next;

    // captured item
    logic [31:0] samp_reg, samp_next;
    logic [31:0] ax_reg, ax_next;
    logic [31:0] ay_reg, ay_next;
    logic [19:0] idx_reg, idx_next;
    logic        last_reg, last_next;
    logic [63:0] sqx_reg, sqx_next;
    logic        sq_y_reg, sq_y_next;
    logic        neg_reg, neg_next;

    // result register
    logic        ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic [19:0] opos_reg, opos_next;
    logic        ofill_reg, ofill_next;

    gcpr_pkg::state_t state_reg, state_next;

    // serial units
    logic mul_start, sqrt_start, div_start;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod, div_q, div_n;
    logic [31:0] root;
    gcpr_pkg::unit_ctl_t mul_ctl, sqrt_ctl, div_ctl;

    logic signed [32:0] dx_w, dy_w;
    logic [64:0] d2_w;
    logic [63:0] d2_sat;
    logic signed [63:0] prod_s;
    logic signed [64:0] sum_w;
    logic [64:0] dtot_w;
    logic [63:0] mag_w;
    logic [63:0] q_w;
    logic signed [63:0] mean_q;

    gcpr_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(mul_b), .ctl(mul_ctl), .prod(mul_prod)
    );

    gcpr_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .radicand(d2_sat), .ctl(sqrt_ctl), .root(root)
    );

    gcpr_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_n), .divisor(mode_reg == gcpr_pkg::MODE_WMEAN ? dtot_reg
                                   : 64'(cnt_reg)),
        .ctl(div_ctl), .quotient(div_q)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= gcpr_pkg::MODE_MEAN;
            in_fill_reg <= gcpr_pkg::FILL_RESET;
            out_fill_reg <= gcpr_pkg::FILL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcpr_pkg::REG_MODE:     mode_reg <= cfg_data[1:0];
                gcpr_pkg::REG_IN_FILL:  in_fill_reg <= cfg_data;
                gcpr_pkg::REG_OUT_FILL: out_fill_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = (state_reg == gcpr_pkg::ST_IDLE) && !ovalid_reg;
    assign dx_w = 33'(centre_x) - 33'(point_x);
    assign dy_w = 33'(centre_y) - 33'(point_y);
    assign d2_w = {1'b0, sqx_reg} + {1'b0, mul_prod};
    assign d2_sat = d2_w[64] ? '1 : d2_w[63:0];
    assign prod_s = signed'(mul_prod);
    assign mag_w = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
    assign div_n = mag_w;
    assign q_w = (div_q > 64'h8000_0000) ? 64'h8000_0000 : div_q;
    assign mean_q = neg_reg ? -signed'(q_w) : signed'(q_w);

    always_comb
    begin
        state_next = state_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        dtot_next = dtot_reg;
        nd2_next = nd2_reg;
        nval_next = nval_reg;
        nseen_next = nseen_reg;
        samp_next = samp_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        idx_next = idx_reg;
        last_next = last_reg;
        sqx_next = sqx_reg;
        sq_y_next = sq_y_reg;
        neg_next = neg_reg;
        ovalid_next = ovalid_reg;
        oval_next = oval_reg;
        opos_next = opos_reg;
        ofill_next = ofill_reg;
        mul_start = 1'b0;
        sqrt_start = 1'b0;
        div_start = 1'b0;
        mul_a = ax_reg;
        mul_b = ax_reg;
        sum_w = '0;
        dtot_w = '0;

        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            gcpr_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    samp_next = sample_value;
                    ax_next = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
                    ay_next = dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
                    idx_next = cell_index;
                    last_next = last_point || !has_point;
                    if (has_point && cnt_reg < CNT_MAX
                        && (mode_reg == gcpr_pkg::MODE_NEAREST
                            || mode_reg == gcpr_pkg::MODE_WMEAN)
                        && (mode_reg == gcpr_pkg::MODE_NEAREST
                            || sample_value != in_fill_reg))
                    begin
                        sq_y_next = 1'b0;
                        state_next = gcpr_pkg::ST_SQUARE;
                    end
                    else if (has_point && cnt_reg < CNT_MAX
                             && sample_value != in_fill_reg
                             && mode_reg != gcpr_pkg::MODE_NEAREST)
                    begin
                        // plain mean: add the sample directly
                        sum_w = 65'(signed'(sum_reg)) + 65'(signed'(sample_value));
                        sum_next = (sum_w[64] != sum_w[63])
                                   ? (sum_w[64] ? S64_MIN : S64_MAX) : sum_w[63:0];
                        cnt_next = cnt_reg + 1'b1;
                        state_next = gcpr_pkg::ST_ACCUM;
                    end
                    else
                        state_next = gcpr_pkg::ST_ACCUM;
                    if (state_next == gcpr_pkg::ST_SQUARE)
                        mul_start = 1'b1;
                    mul_a = ax_next;
                    mul_b = ax_next;
                end
            end
            gcpr_pkg::ST_SQUARE:
            begin
                if (mul_ctl.done)
                begin
                    if (!sq_y_reg)
                    begin
                        sqx_next = mul_prod;
                        sq_y_next = 1'b1;
                        mul_a = ay_reg;
                        mul_b = ay_reg;
                        mul_start = 1'b1;
                    end
                    else if (mode_reg == gcpr_pkg::MODE_NEAREST)
                    begin
                        if (!nseen_reg || d2_sat < nd2_reg)
                        begin
                            nd2_next = d2_sat;
                            nval_next = samp_reg;
                            nseen_next = 1'b1;
                        end
                        cnt_next = cnt_reg + 1'b1;
                        state_next = gcpr_pkg::ST_ACCUM;
                    end
                    else
                    begin
                        sqrt_start = 1'b1;
                        state_next = gcpr_pkg::ST_ROOT;
                    end
                end
            end
            gcpr_pkg::ST_ROOT:
            begin
                if (sqrt_ctl.done && !mul_ctl.busy && !mul_ctl.done)
                begin
                    // multiply magnitudes, then fix the sign
                    mul_a = samp_reg[31] ? 32'(-samp_reg) : samp_reg;
                    mul_b = root;
                    mul_start = 1'b1;
                    dtot_w = {1'b0, dtot_reg} + 65'(root);
                    dtot_next = dtot_w[64] ? '1 : dtot_w[63:0];
                end
                else if (mul_ctl.done)
                begin
                    sum_w = samp_reg[31] ? 65'(signed'(sum_reg)) - 65'(prod_s)
                                         : 65'(signed'(sum_reg)) + 65'(prod_s);
                    sum_next = (sum_w[64] != sum_w[63])
                               ? (sum_w[64] ? S64_MIN : S64_MAX) : sum_w[63:0];
                    cnt_next = cnt_reg + 1'b1;
                    state_next = gcpr_pkg::ST_ACCUM;
                end
            end
            gcpr_pkg::ST_ACCUM:
            begin
                if (!last_reg)
                    state_next = gcpr_pkg::ST_IDLE;
                else if (mode_reg == gcpr_pkg::MODE_NEAREST)
                begin
                    oval_next = nval_reg;
                    ofill_next = !nseen_reg;
                    if (!nseen_reg)
                        oval_next = '0;
                    state_next = gcpr_pkg::ST_OUTPUT;
                end
                else if ((mode_reg == gcpr_pkg::MODE_WMEAN && dtot_reg == '0)
                         || (mode_reg != gcpr_pkg::MODE_WMEAN && cnt_reg == '0))
                begin
                    oval_next = out_fill_reg;
                    ofill_next = 1'b1;
                    state_next = gcpr_pkg::ST_OUTPUT;
                end
                else
                begin
                    neg_next = sum_reg[63];
                    div_start = 1'b1;
                    state_next = gcpr_pkg::ST_DIVIDE;
                end
            end
            gcpr_pkg::ST_DIVIDE:
            begin
                if (div_ctl.done)
                begin
                    ofill_next = 1'b0;
                    if (mean_q > 64'sh7FFF_FFFF)
                        oval_next = 32'h7FFF_FFFF;
                    else
                        oval_next = mean_q[31:0];
                    state_next = gcpr_pkg::ST_OUTPUT;
                end
            end
            gcpr_pkg::ST_OUTPUT:
            begin
                // emit the result and clear the cell
                ovalid_next = 1'b1;
                opos_next = idx_reg;
                sum_next = '0;
                cnt_next = '0;
                dtot_next = '0;
                nd2_next = '1;
                nval_next = '0;
                nseen_next = 1'b0;
                state_next = gcpr_pkg::ST_IDLE;
            end
            default: state_next = gcpr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcpr_pkg::ST_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
            dtot_reg <= '0;
            nd2_reg <= '1;
            nval_reg <= '0;
            nseen_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            sq_y_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            dtot_reg <= dtot_next;
            nd2_reg <= nd2_next;
            nval_reg <= nval_next;
            nseen_reg <= nseen_next;
            ovalid_reg <= ovalid_next;
            sq_y_reg <= sq_y_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        idx_reg <= idx_next;
        sqx_reg <= sqx_next;
        neg_reg <= neg_next;
        oval_reg <= oval_next;
        opos_reg <= opos_next;
        ofill_reg <= ofill_next;
    end

    assign out_valid = ovalid_reg;
    assign cell_value = oval_reg;
    assign cell_position = opos_reg;
    assign used_fill = ofill_reg;
endmodule

[rtl/core/gcpr_checker.sv]
// port-level checks for the grid cell point reduction block, with bind
`include "grid_cell_point_reduction_core_assert.svh"
module gcpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] cell_value,
    input logic        used_fill
);
    // a held result keeps its value
    `GCPR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(cell_value), "result changed while stalled")
    // a held result keeps its fill flag
    `GCPR_ASSERT_NEXT(a_fill_hold, clk, rst_n, out_valid && !out_ready, $stable(used_fill), "fill flag changed while stalled")
    // no item taken while a result waits
    `GCPR_ASSERT_IMPL(a_no_accept_pending, clk, rst_n, out_valid, !in_ready, "input taken with result pending")
    // an input transfer closes the ready window
    `GCPR_ASSERT_NEXT(a_ready_drops, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after transfer")
endmodule

bind grid_cell_point_reduction_core gcpr_checker u_gcpr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cell_value(cell_value),
    .used_fill(used_fill)
);
